[src/swms_pkg.sv]
// Shared types and constants for the sliding-window median/statistics block.
package swms_pkg;

    localparam int DATA_W = 16;
    localparam int SLOT_W = 6;
    localparam int QUO_W  = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SET    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_REMOVE,
        ST_INSERT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic remove;
        logic insert;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic ignore;
    } status_t;

endpackage

[src/swms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module swms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/swms_ctrl.sv]
// Controller state machine: sequences window update, sorted-list update and division.
module swms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             out_stall,
    output logic             out_valid,
    output swms_pkg::cmd_t   cmd,
    input  swms_pkg::status_t status
);

    swms_pkg::state_t               state_reg;
    swms_pkg::state_t               state_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swms_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = swms_pkg::ST_READ;
                end
            end
            swms_pkg::ST_READ:
            begin
                if (status.ignore)
                begin
                    state_next = swms_pkg::ST_DIV;
                end
                else
                begin
                    state_next = swms_pkg::ST_REMOVE;
                end
            end
            swms_pkg::ST_REMOVE:
            begin
                state_next = swms_pkg::ST_INSERT;
            end
            swms_pkg::ST_INSERT:
            begin
                state_next = swms_pkg::ST_DIV;
            end
            swms_pkg::ST_DIV:
            begin
                state_next = swms_pkg::ST_DONE;
            end
            swms_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = swms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swms_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            swms_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            swms_pkg::ST_READ:
            begin
                cmd.read     = !status.ignore;
                cmd.div_init = status.ignore;
            end
            swms_pkg::ST_REMOVE:
            begin
                cmd.remove = 1'b1;
            end
            swms_pkg::ST_INSERT:
            begin
                cmd.insert   = 1'b1;
                cmd.div_init = 1'b1;
            end
            swms_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            swms_pkg::ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swms_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == swms_pkg::ST_READ))
        else $error("accepted transaction did not start a window read");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swms_pkg::ST_DIV) |=> (state_reg == swms_pkg::ST_DONE))
        else $error("average step did not hand over to the result state");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == swms_pkg::ST_DONE))
        else $error("result raised outside the done state");

endmodule

[src/swms_datapath.sv]
// Datapath: window RAM, sorted sample list, running sum and reciprocal-multiply average.
module swms_datapath #(
    parameter int WINDOW = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swms_pkg::cmd_t                     cmd,
    output swms_pkg::status_t                  status,
    input  logic                               operation,
    input  logic [swms_pkg::SLOT_W-1:0]        slot_index,
    input  logic signed [swms_pkg::DATA_W-1:0] sample_value,
    output logic signed [swms_pkg::DATA_W-1:0] median,
    output logic signed [swms_pkg::DATA_W-1:0] minimum,
    output logic signed [swms_pkg::DATA_W-1:0] maximum,
    output logic signed [swms_pkg::DATA_W-1:0] average,
    output logic                               write_ignored
);

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int REM_W   = $clog2(WINDOW) + 1;
    localparam int SUM_W   = swms_pkg::QUO_W + REM_W;
    localparam int SHIFT   = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [SUM_W-1:0] BIAS = SUM_W'(WINDOW) << (swms_pkg::QUO_W - 1);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic                               op_reg;
    logic [swms_pkg::SLOT_W-1:0]        idx_reg;
    logic signed [swms_pkg::DATA_W-1:0] val_reg;
    logic [IDX_W-1:0]                   head_reg;
    logic [IDX_W-1:0]                   head_next;
    logic                               valid_reg [WINDOW];
    logic                               rd_valid_reg;
    logic signed [swms_pkg::DATA_W-1:0] sorted_reg [WINDOW];
    logic signed [swms_pkg::DATA_W-1:0] sorted_next [WINDOW];
    logic signed [swms_pkg::DATA_W-1:0] removed [WINDOW];
    logic signed [swms_pkg::DATA_W-1:0] inserted [WINDOW];
    logic signed [SUM_W-1:0]            sum_reg;
    logic signed [SUM_W-1:0]            sum_next;
    logic [SUM_W-1:0]                   biased;
    logic [SUM_W-1:0]                   dividend_reg;
    logic [SUM_W-1:0]                   dividend_next;
    logic [PROD_W-1:0]                  product;
    logic [swms_pkg::QUO_W-1:0]         quo_reg;
    logic [swms_pkg::QUO_W-1:0]         quo_next;
    logic signed [swms_pkg::DATA_W-1:0] median_reg;
    logic signed [swms_pkg::DATA_W-1:0] minimum_reg;
    logic signed [swms_pkg::DATA_W-1:0] maximum_reg;
    logic signed [swms_pkg::DATA_W-1:0] average_reg;
    logic                               ignored_reg;
    logic [IDX_W:0]                     set_sum;
    logic [IDX_W-1:0]                   set_addr;
    logic [IDX_W-1:0]                   ins_addr;
    logic [IDX_W-1:0]                   phys_addr;
    logic [swms_pkg::DATA_W-1:0]        ram_rdata;
    logic signed [swms_pkg::DATA_W-1:0] old_val;
    logic                               sorted_ok;

    assign status.ignore = (op_reg == swms_pkg::OP_SET)
                           && ({1'b0, idx_reg} >= (swms_pkg::SLOT_W + 1)'(WINDOW));

    // logical slot -> physical entry of the circular buffer
    assign set_sum  = {1'b0, head_reg} + {1'b0, idx_reg[IDX_W-1:0]};
    assign set_addr = (set_sum >= (IDX_W + 1)'(WINDOW))
                      ? IDX_W'(set_sum - (IDX_W + 1)'(WINDOW)) : set_sum[IDX_W-1:0];
    assign ins_addr = (head_reg == '0) ? IDX_W'(WINDOW - 1) : head_reg - 1'b1;
    assign phys_addr = (op_reg == swms_pkg::OP_INSERT) ? ins_addr : set_addr;

    swms_ram #(
        .WIDTH (swms_pkg::DATA_W),
        .DEPTH (WINDOW)
    ) u_window_ram (
        .clk   (clk),
        .we    (cmd.remove),
        .waddr (phys_addr),
        .wdata (val_reg),
        .re    (cmd.read),
        .raddr (phys_addr),
        .rdata (ram_rdata)
    );

    assign old_val = rd_valid_reg ? $signed(ram_rdata) : '0;

    // sorted list: drop one copy of the old sample, then place the new one
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            removed[i] = sorted_reg[i];
            if (i < WINDOW - 1)
            begin
                if (sorted_reg[i] >= old_val)
                begin
                    removed[i] = sorted_reg[i + 1];
                end
            end
        end
        inserted[0] = (sorted_reg[0] > val_reg) ? val_reg : sorted_reg[0];
        for (int i = 1; i < WINDOW; i++)
        begin
            if (sorted_reg[i - 1] > val_reg)
            begin
                inserted[i] = sorted_reg[i - 1];
            end
            else if (i == WINDOW - 1 || sorted_reg[i] > val_reg)
            begin
                inserted[i] = val_reg;
            end
            else
            begin
                inserted[i] = sorted_reg[i];
            end
        end
        for (int i = 0; i < WINDOW; i++)
        begin
            if (cmd.remove)
            begin
                sorted_next[i] = removed[i];
            end
            else if (cmd.insert)
            begin
                sorted_next[i] = inserted[i];
            end
            else
            begin
                sorted_next[i] = sorted_reg[i];
            end
        end
    end

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 0; i < WINDOW - 1; i++)
        begin
            if (sorted_reg[i] > sorted_reg[i + 1])
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    assign head_next = (cmd.remove && op_reg == swms_pkg::OP_INSERT) ? ins_addr : head_reg;
    assign sum_next  = cmd.remove
                       ? sum_reg + SUM_W'(val_reg) - SUM_W'(old_val) : sum_reg;

    // floor(sum / WINDOW): offset to nonnegative, then multiply by the rounded-up reciprocal
    assign biased  = $unsigned(sum_reg) + BIAS;
    assign product = PROD_W'(dividend_reg) * PROD_W'(RECIP);

    always_comb
    begin
        dividend_next = dividend_reg;
        quo_next      = quo_reg;
        if (cmd.div_init)
        begin
            dividend_next = biased;
        end
        if (cmd.div_step)
        begin
            quo_next = product[SHIFT +: swms_pkg::QUO_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            sum_reg      <= '0;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW; i++)
            begin
                valid_reg[i]  <= 1'b0;
                sorted_reg[i] <= '0;
            end
        end
        else
        begin
            head_reg <= head_next;
            sum_reg  <= sum_next;
            if (cmd.read)
            begin
                rd_valid_reg <= valid_reg[phys_addr];
            end
            if (cmd.remove)
            begin
                valid_reg[phys_addr] <= 1'b1;
            end
            for (int i = 0; i < WINDOW; i++)
            begin
                sorted_reg[i] <= sorted_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            idx_reg <= slot_index;
            val_reg <= sample_value;
        end
        dividend_reg <= dividend_next;
        quo_reg      <= quo_next;
        if (cmd.out_load)
        begin
            median_reg  <= sorted_reg[WINDOW / 2];
            minimum_reg <= sorted_reg[0];
            maximum_reg <= sorted_reg[WINDOW - 1];
            average_reg <= {~quo_reg[swms_pkg::QUO_W-1], quo_reg[swms_pkg::QUO_W-2:0]};
            ignored_reg <= status.ignore;
        end
    end

    assign median        = median_reg;
    assign minimum       = minimum_reg;
    assign maximum       = maximum_reg;
    assign average       = average_reg;
    assign write_ignored = ignored_reg;

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> sorted_ok)
        else $error("sorted sample list out of order between transactions");

    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (product[PROD_W-1:SHIFT+swms_pkg::QUO_W] == '0))
        else $error("average quotient wider than the output field");

    a_no_write_on_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.remove || cmd.read) |-> !status.ignore)
        else $error("window touched by an out-of-range set");

endmodule

[src/sliding_window_median_stats_core.sv]
// Top level: sliding-window median, minimum, maximum and average of Q8.8 samples.
// Each input transaction steps through window read, sorted-list remove and insert,
// one reciprocal multiply and result load; an out-of-range set skips read, remove and
// insert. A new transaction is taken only once the result is loaded; an output stall holds it.
// Reset marks every window entry empty (read as zero), clears the sorted list to zero and leaves no result pending.
module sliding_window_median_stats_core #(
    parameter int WINDOW = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [swms_pkg::SLOT_W-1:0]        slot_index,
    input  logic signed [swms_pkg::DATA_W-1:0] sample_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [swms_pkg::DATA_W-1:0] median,
    output logic signed [swms_pkg::DATA_W-1:0] minimum,
    output logic signed [swms_pkg::DATA_W-1:0] maximum,
    output logic signed [swms_pkg::DATA_W-1:0] average,
    output logic                               write_ignored
);

    swms_pkg::cmd_t    cmd;
    swms_pkg::status_t status;

    swms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .status    (status)
    );

    swms_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .slot_index    (slot_index),
        .sample_value  (sample_value),
        .median        (median),
        .minimum       (minimum),
        .maximum       (maximum),
        .average       (average),
        .write_ignored (write_ignored)
    );

endmodule

[dv/sliding_window_stats_checker.sv]
// Checker for the sliding-window statistics core: tracks the window and compares every result.
`timescale 1ns / 100ps

module sliding_window_stats_checker #(
    parameter int WINDOW = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                operation,
    input  logic [swms_pkg::SLOT_W-1:0]         slot_index,
    input  logic signed [swms_pkg::DATA_W-1:0]  sample_value,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [swms_pkg::DATA_W-1:0]  median,
    input  logic signed [swms_pkg::DATA_W-1:0]  minimum,
    input  logic signed [swms_pkg::DATA_W-1:0]  maximum,
    input  logic signed [swms_pkg::DATA_W-1:0]  average,
    input  logic                                write_ignored,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  result_count
);

    typedef struct packed {
        logic signed [swms_pkg::DATA_W-1:0] median;
        logic signed [swms_pkg::DATA_W-1:0] minimum;
        logic signed [swms_pkg::DATA_W-1:0] maximum;
        logic signed [swms_pkg::DATA_W-1:0] average;
        logic                               write_ignored;
    } stats_t;

    logic signed [swms_pkg::DATA_W-1:0] win [WINDOW];
    stats_t                             expected_stats [$];

    function automatic stats_t window_stats(input logic ignored);
        logic signed [swms_pkg::DATA_W-1:0] ordered [WINDOW];
        logic signed [swms_pkg::DATA_W-1:0] key;
        int                                 total;
        int                                 quo;
        int                                 j;
        stats_t                             s;
        total = 0;
        for (int i = 0; i < WINDOW; i++)
        begin
            ordered[i] = win[i];
            total += win[i];
        end
        for (int i = 1; i < WINDOW; i++)
        begin
            key = ordered[i];
            j = i - 1;
            while (j >= 0 && ordered[j] > key)
            begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = key;
        end
        // floor division, also for negative sums
        quo = total / WINDOW;
        if (total < 0 && (total % WINDOW) != 0)
        begin
            quo--;
        end
        s.median        = ordered[WINDOW / 2];
        s.minimum       = ordered[0];
        s.maximum       = ordered[WINDOW - 1];
        s.average       = quo[swms_pkg::DATA_W-1:0];
        s.write_ignored = ignored;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        stats_t want;
        stats_t seen;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                win[i] = '0;
            end
            expected_stats.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                seen = '{median, minimum, maximum, average, write_ignored};
                if (expected_stats.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: result with nothing pending", $realtime);
                        $display("    actual   med %0d min %0d max %0d avg %0d ign %0b",
                                 seen.median, seen.minimum, seen.maximum,
                                 seen.average, seen.write_ignored);
                    end
                end
                else
                begin
                    want = expected_stats.pop_front();
                    if (seen.median !== want.median || seen.minimum !== want.minimum ||
                        seen.maximum !== want.maximum || seen.average !== want.average ||
                        seen.write_ignored !== want.write_ignored)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: result %0d mismatch", $realtime, result_count);
                            $display("    expected med %0d min %0d max %0d avg %0d ign %0b",
                                     want.median, want.minimum, want.maximum,
                                     want.average, want.write_ignored);
                            $display("    actual   med %0d min %0d max %0d avg %0d ign %0b",
                                     seen.median, seen.minimum, seen.maximum,
                                     seen.average, seen.write_ignored);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (operation == swms_pkg::OP_INSERT)
                begin
                    for (int i = WINDOW - 1; i > 0; i--)
                    begin
                        win[i] = win[i - 1];
                    end
                    win[0] = sample_value;
                    expected_stats.push_back(window_stats(1'b0));
                end
                else if (slot_index < WINDOW)
                begin
                    win[slot_index] = sample_value;
                    expected_stats.push_back(window_stats(1'b0));
                end
                else
                begin
                    expected_stats.push_back(window_stats(1'b1));
                end
            end
        end
        pending = expected_stats.size();
    end

endmodule

[dv/tb_sliding_window_median_stats_core.sv]
// Testbench top for the sliding-window statistics core: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_sliding_window_median_stats_core;

    localparam int WINDOW       = 8;
    localparam int RANDOM_ITEMS = 1528;
    localparam int CALM_ITEMS   = 200;
    localparam int HOLD_START   = 300;
    localparam int HOLD_CYCLES  = 400;

    localparam logic signed [swms_pkg::DATA_W-1:0] EDGE_SAMPLES [4] =
        '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                in_valid     = 1'b0;
    logic                                in_stall;
    logic                                operation    = swms_pkg::OP_INSERT;
    logic [swms_pkg::SLOT_W-1:0]         slot_index   = '0;
    logic signed [swms_pkg::DATA_W-1:0]  sample_value = '0;
    logic                                out_valid;
    logic                                out_stall    = 1'b0;
    logic signed [swms_pkg::DATA_W-1:0]  median;
    logic signed [swms_pkg::DATA_W-1:0]  minimum;
    logic signed [swms_pkg::DATA_W-1:0]  maximum;
    logic signed [swms_pkg::DATA_W-1:0]  average;
    logic                                write_ignored;

    int fail_count;
    int pending;
    int result_count;

    int   sent_count;
    int   insert_count;
    int   set_count;
    int   ignored_count;
    int   gap_pct;
    int   stall_pct;
    bit   quiet;
    bit   hold_done;
    logic signed [swms_pkg::DATA_W-1:0] prev_sample;

    sliding_window_median_stats_core #(.WINDOW(WINDOW)) dut (.*);

    sliding_window_stats_checker #(.WINDOW(WINDOW)) stats_checker (.*);

    always #5 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("tb_sliding_window_median_stats_core: done, errors");
        $finish;
    end

    function automatic logic signed [swms_pkg::DATA_W-1:0] pick_sample();
        logic signed [swms_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = (swms_pkg::DATA_W)'($urandom_range(0, 65535));
            1:       v = (swms_pkg::DATA_W)'($urandom_range(0, 1023) - 512);
            2:       v = EDGE_SAMPLES[$urandom_range(0, 3)];
            default: v = prev_sample;
        endcase
        prev_sample = v;
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_sample(input logic op, input logic [swms_pkg::SLOT_W-1:0] idx,
                                input logic signed [swms_pkg::DATA_W-1:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 13);
            in_valid     <= 1'b0;
            operation    <= 1'($urandom_range(0, 1));
            slot_index   <= (swms_pkg::SLOT_W)'($urandom_range(0, 63));
            sample_value <= (swms_pkg::DATA_W)'($urandom_range(0, 65535));
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        slot_index   <= idx;
        sample_value <= val;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent_count++;
        if (op == swms_pkg::OP_INSERT)
        begin
            insert_count++;
        end
        else
        begin
            set_count++;
            if (idx >= WINDOW)
            begin
                ignored_count++;
            end
        end
        @(negedge clk);
    endtask

    // receiver flow control
    initial
    begin
        int burst;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent_count >= HOLD_START)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                burst = $urandom_range(1, 13);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic                        op;
        logic [swms_pkg::SLOT_W-1:0] idx;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: sign extremes, floor of a negative mean, full window at max,
        // first and last slots, out-of-range indexes, alternating bit patterns
        offer_sample(swms_pkg::OP_INSERT, 6'd0, 16'shFFFF);
        offer_sample(swms_pkg::OP_INSERT, 6'd63, 16'sh0001);
        repeat (WINDOW) offer_sample(swms_pkg::OP_INSERT, 6'd0, 16'sh7FFF);
        offer_sample(swms_pkg::OP_SET, 6'd7, 16'sh8000);
        offer_sample(swms_pkg::OP_SET, 6'd0, 16'sh8000);
        offer_sample(swms_pkg::OP_SET, 6'd8, 16'sh04D2);
        offer_sample(swms_pkg::OP_SET, 6'd63, 16'shFFFF);
        offer_sample(swms_pkg::OP_SET, 6'd3, 16'sh0000);
        offer_sample(swms_pkg::OP_INSERT, 6'd21, 16'sh8000);
        offer_sample(swms_pkg::OP_INSERT, 6'd42, 16'sh5555);
        offer_sample(swms_pkg::OP_INSERT, 6'd0, 16'shAAAA);
        offer_sample(swms_pkg::OP_SET, 6'd32, 16'sh0000);
        offer_sample(swms_pkg::OP_INSERT, 6'd0, 16'sh0100);
        offer_sample(swms_pkg::OP_INSERT, 6'd0, 16'shFF00);
        offer_sample(swms_pkg::OP_SET, 6'd4, 16'sh0007);
        offer_sample(swms_pkg::OP_SET, 6'd1, 16'sh7FFF);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                gap_pct   = 15 * $urandom_range(0, 3);
                stall_pct = 15 * $urandom_range(0, 3);
            end
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                quiet = 1'b1;
            end
            op = ($urandom_range(0, 99) < 55) ? swms_pkg::OP_INSERT : swms_pkg::OP_SET;
            if (op == swms_pkg::OP_SET && $urandom_range(0, 3) != 0)
            begin
                idx = (swms_pkg::SLOT_W)'($urandom_range(0, WINDOW - 1));
            end
            else
            begin
                idx = (swms_pkg::SLOT_W)'($urandom_range(0, 63));
            end
            offer_sample(op, idx, pick_sample());
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (40) @(posedge clk);

        $display("Covered %0d inserts and %0d slot writes (%0d out of range), %0d results checked,",
                 insert_count, set_count, ignored_count, result_count);
        $display("with random gaps and stalls plus one %0d-cycle output hold.", HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb_sliding_window_median_stats_core: done, clean");
        end
        else
        begin
            $display("tb_sliding_window_median_stats_core: done, errors");
        end
        $finish;
    end

endmodule
